### hdl/byte_array_insert_remove_engine_macros.svh
// ----------------------------------------------------------------------------
// Byte array engine assertion macros
// Shared concurrent assertion forms for the byte array engine modules.
// ----------------------------------------------------------------------------
`ifndef BYTE_ARRAY_INSERT_REMOVE_ENGINE_MACROS_SVH
`define BYTE_ARRAY_INSERT_REMOVE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BAIR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BAIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bair_pkg.sv
// ----------------------------------------------------------------------------
// Byte array engine package
// Field widths, request mode codes, work plans and controller links.
// ----------------------------------------------------------------------------
package bair_pkg;

    localparam int MODE_W  = 4;
    localparam int INDEX_W = 9;
    localparam int WCODE_W = 2;
    localparam int VALUE_W = 32;
    localparam int LEVEL_W = 9;
    localparam int BYTE_W  = 8;

    localparam logic [MODE_W-1:0] MODE_APPEND    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_REPLACE   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_READ_AT   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_READ_LAST = 4'd5;
    localparam logic [MODE_W-1:0] MODE_TAKE_LAST = 4'd6;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 4'd7;
    localparam logic [MODE_W-1:0] MODE_FILL      = 4'd8;
    localparam logic [MODE_W-1:0] MODE_RESIZE    = 4'd9;

    localparam logic [WCODE_W-1:0] WC_ONE  = 2'd0;
    localparam logic [WCODE_W-1:0] WC_TWO  = 2'd1;
    localparam logic [WCODE_W-1:0] WC_FOUR = 2'd2;

    typedef logic [2:0] t_plan;

    localparam t_plan PLAN_NONE      = 3'd0;
    localparam t_plan PLAN_WRITE     = 3'd1;
    localparam t_plan PLAN_READ      = 3'd2;
    localparam t_plan PLAN_MOVE_UP   = 3'd3;
    localparam t_plan PLAN_MOVE_DOWN = 3'd4;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic wr_step;
        logic rd_issue;
        logic rd_cap;
        logic mv_read;
        logic mv_write;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_plan plan;
        logic  cnt_zero;
        logic  cnt_one;
        logic  init_last;
        logic  out_free;
    } t_status;

endpackage

### hdl/bair_if.sv
// ----------------------------------------------------------------------------
// Byte array engine channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bair_req_if;
    logic                           valid;
    logic                           ready;
    logic [bair_pkg::MODE_W-1:0]    mode;
    logic [bair_pkg::INDEX_W-1:0]   index;
    logic [bair_pkg::WCODE_W-1:0]   width_code;
    logic [bair_pkg::VALUE_W-1:0]   write_value;

    modport source (output valid, output mode, output index, output width_code,
                    output write_value, input ready);
    modport sink   (input valid, input mode, input index, input width_code,
                    input write_value, output ready);
endinterface

interface bair_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bair_pkg::VALUE_W-1:0]   read_value;
    logic                           ok;
    logic [bair_pkg::LEVEL_W-1:0]   fill_level;

    modport source (output valid, output read_value, output ok, output fill_level,
                    input ready);
    modport sink   (input valid, input read_value, input ok, input fill_level,
                    output ready);
endinterface

### hdl/bair_dp.sv
// ----------------------------------------------------------------------------
// Byte array engine datapath
// Byte memory, fill level, request checks, pointers and the result register.
// ----------------------------------------------------------------------------
`include "byte_array_insert_remove_engine_macros.svh"

module bair_dp #(
    parameter int STORE_BYTES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bair_pkg::t_cmd                i_cmd,
    output bair_pkg::t_status             o_status,
    input  logic [bair_pkg::MODE_W-1:0]   i_mode,
    input  logic [bair_pkg::INDEX_W-1:0]  i_index,
    input  logic [bair_pkg::WCODE_W-1:0]  i_width_code,
    input  logic [bair_pkg::VALUE_W-1:0]  i_write_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bair_pkg::VALUE_W-1:0]  o_read_value,
    output logic                          o_ok,
    output logic [bair_pkg::LEVEL_W-1:0]  o_fill_level
);

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CW = $clog2(STORE_BYTES + 1);
    localparam int XW = ((CW > bair_pkg::INDEX_W) ? CW : bair_pkg::INDEX_W) + 1;
    localparam logic [XW-1:0] STORE_X = XW'(STORE_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

    logic [bair_pkg::BYTE_W-1:0]  r_mem [STORE_BYTES];
    logic [bair_pkg::BYTE_W-1:0]  r_rdata;

    logic [CW-1:0]                r_used;
    logic [AW-1:0]                r_ptr;
    logic [CW-1:0]                r_cnt;
    logic [bair_pkg::VALUE_W-1:0] r_shift;
    logic [bair_pkg::VALUE_W-1:0] r_acc;
    logic                         r_ok;
    bair_pkg::t_plan              r_plan;

    logic                         r_out_valid;
    logic [bair_pkg::VALUE_W-1:0] r_out_value;
    logic                         r_out_ok;
    logic [bair_pkg::LEVEL_W-1:0] r_out_level;

    logic [XW-1:0]                c_u;
    logic [XW-1:0]                c_x;
    logic [XW-1:0]                c_n;
    logic                         c_ok;
    bair_pkg::t_plan              c_plan;
    logic [AW-1:0]                c_ptr;
    logic [CW-1:0]                c_cnt;
    logic [CW-1:0]                c_used;
    logic [bair_pkg::VALUE_W-1:0] c_shift;

    logic                         w_up;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [bair_pkg::BYTE_W-1:0]  w_wdata;
    logic [AW-1:0]                w_raddr;

    // Request check and work plan, taken from the request fields and the
    // fill level while the engine is idle.
    always_comb begin
        c_u    = XW'(r_used);
        c_x    = XW'(i_index);
        c_ok   = 1'b0;
        c_plan = bair_pkg::PLAN_NONE;
        c_ptr  = r_ptr;
        c_cnt  = '0;
        c_used = r_used;
        case (i_width_code)
            bair_pkg::WC_ONE:  c_n = XW'(1);
            bair_pkg::WC_TWO:  c_n = XW'(2);
            bair_pkg::WC_FOUR: c_n = XW'(4);
            default:           c_n = '0;
        endcase
        case (i_width_code)
            bair_pkg::WC_ONE:  c_shift = {i_write_value[7:0], 24'h0};
            bair_pkg::WC_TWO:  c_shift = {i_write_value[15:0], 16'h0};
            default:           c_shift = i_write_value;
        endcase
        case (i_mode)
            bair_pkg::MODE_APPEND: begin
                if (c_n != '0 && c_u + c_n <= STORE_X) begin
                    c_ok   = 1'b1;
                    c_plan = bair_pkg::PLAN_WRITE;
                    c_ptr  = AW'(c_u);
                    c_cnt  = CW'(c_n);
                    c_used = CW'(c_u + c_n);
                end
            end
            bair_pkg::MODE_INSERT: begin
                c_shift = {i_write_value[7:0], 24'h0};
                if (c_x <= c_u && c_u < STORE_X) begin
                    c_ok   = 1'b1;
                    c_plan = bair_pkg::PLAN_MOVE_UP;
                    c_ptr  = AW'(c_u);
                    c_cnt  = CW'(c_u - c_x);
                    c_used = CW'(c_u + XW'(1));
                end
            end
            bair_pkg::MODE_REMOVE: begin
                if (c_x < c_u) begin
                    c_ok   = 1'b1;
                    c_plan = bair_pkg::PLAN_MOVE_DOWN;
                    c_ptr  = AW'(c_x);
                    c_cnt  = CW'(c_u - c_x - XW'(1));
                    c_used = CW'(c_u - XW'(1));
                end
            end
            bair_pkg::MODE_REPLACE: begin
                if (c_n != '0 && c_x + c_n <= c_u) begin
                    c_ok   = 1'b1;
                    c_plan = bair_pkg::PLAN_WRITE;
                    c_ptr  = AW'(c_x);
                    c_cnt  = CW'(c_n);
                end
            end
            bair_pkg::MODE_READ_AT: begin
                if (c_n != '0 && c_x + c_n <= c_u) begin
                    c_ok   = 1'b1;
                    c_plan = bair_pkg::PLAN_READ;
                    c_ptr  = AW'(c_x);
                    c_cnt  = CW'(c_n);
                end
            end
            bair_pkg::MODE_READ_LAST, bair_pkg::MODE_TAKE_LAST: begin
                if (c_n != '0 && c_u >= c_n) begin
                    c_ok   = 1'b1;
                    c_plan = bair_pkg::PLAN_READ;
                    c_ptr  = AW'(c_u - c_n);
                    c_cnt  = CW'(c_n);
                    if (i_mode == bair_pkg::MODE_TAKE_LAST) begin
                        c_used = CW'(c_u - c_n);
                    end
                end
            end
            bair_pkg::MODE_CLEAR: begin
                c_ok   = 1'b1;
                c_used = '0;
            end
            bair_pkg::MODE_FILL: begin
                // Replicated byte, so rotating the word keeps the same byte on top.
                c_shift = {4{i_write_value[7:0]}};
                c_ok    = 1'b1;
                c_plan  = bair_pkg::PLAN_WRITE;
                c_ptr   = '0;
                c_cnt   = r_used;
            end
            bair_pkg::MODE_RESIZE: begin
                if (c_x <= STORE_X) begin
                    c_ok   = 1'b1;
                    c_used = CW'(c_x);
                end
            end
            default: begin
                c_ok = 1'b0;
            end
        endcase
    end

    assign w_up    = (r_plan == bair_pkg::PLAN_MOVE_UP);
    assign w_we    = i_cmd.clr_step | i_cmd.wr_step | i_cmd.mv_write;
    assign w_waddr = r_ptr;
    assign w_raddr = i_cmd.mv_read ? (w_up ? r_ptr - AW'(1) : r_ptr + AW'(1)) : r_ptr;

    always_comb begin
        if (i_cmd.mv_write) begin
            w_wdata = r_rdata;
        end else if (i_cmd.wr_step) begin
            w_wdata = r_shift[31:24];
        end else begin
            w_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_ptr  <= '0;
            r_plan <= bair_pkg::PLAN_NONE;
        end else if (i_cmd.load) begin
            r_used <= c_ok ? c_used : r_used;
            r_ptr  <= c_ptr;
            r_plan <= c_ok ? c_plan : bair_pkg::PLAN_NONE;
        end else if (i_cmd.clr_step || i_cmd.wr_step || i_cmd.rd_issue) begin
            r_ptr <= r_ptr + AW'(1);
        end else if (i_cmd.mv_write) begin
            r_ptr <= w_up ? r_ptr - AW'(1) : r_ptr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cnt   <= c_cnt;
            r_shift <= c_shift;
            r_acc   <= '0;
            r_ok    <= c_ok;
        end else begin
            if (i_cmd.wr_step || i_cmd.rd_issue || i_cmd.mv_write) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.wr_step) begin
                r_shift <= {r_shift[23:0], r_shift[31:24]};
            end
            if (i_cmd.rd_cap) begin
                r_acc <= {r_acc[23:0], r_rdata};
            end
        end
    end

    // Result register: a finished transaction waits here while the next
    // request is already being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value <= r_acc;
            r_out_ok    <= r_ok;
            r_out_level <= bair_pkg::LEVEL_W'(r_used);
        end
    end

    assign o_status.plan      = r_plan;
    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_status.cnt_one   = (r_cnt == CW'(1));
    assign o_status.init_last = (r_ptr == LAST_ADDR);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_ok         = r_out_ok;
    assign o_fill_level = r_out_level;

    `BAIR_ASSERT_IMP(a_used_in_range, i_clk, i_rst_n, 1'b1, XW'(r_used) <= STORE_X, "fill level beyond store size")
    `BAIR_ASSERT_NEXT(a_refused_keeps_level, i_clk, i_rst_n, i_cmd.load && !c_ok, $stable(r_used), "refused request changed the fill level")
    `BAIR_ASSERT_NEXT(a_finish_shows_result, i_clk, i_rst_n, i_cmd.finish, r_out_valid, "finished transaction not presented")

endmodule

### hdl/bair_ctrl.sv
// ----------------------------------------------------------------------------
// Byte array engine controller
// Sequences the clearing pass and the per-request memory steps.
// ----------------------------------------------------------------------------
`include "byte_array_insert_remove_engine_macros.svh"

module bair_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bair_pkg::t_status  i_status,
    output bair_pkg::t_cmd     o_cmd
);

    localparam logic [3:0] ST_INIT     = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_START    = 4'd2;
    localparam logic [3:0] ST_WRITE    = 4'd3;
    localparam logic [3:0] ST_RD_ISSUE = 4'd4;
    localparam logic [3:0] ST_RD_CAP   = 4'd5;
    localparam logic [3:0] ST_MV_RD    = 4'd6;
    localparam logic [3:0] ST_MV_WR    = 4'd7;
    localparam logic [3:0] ST_INS_WR   = 4'd8;
    localparam logic [3:0] ST_FINISH   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                case (i_status.plan)
                    bair_pkg::PLAN_WRITE:
                        n_state = i_status.cnt_zero ? ST_FINISH : ST_WRITE;
                    bair_pkg::PLAN_READ:
                        n_state = ST_RD_ISSUE;
                    bair_pkg::PLAN_MOVE_UP:
                        n_state = i_status.cnt_zero ? ST_INS_WR : ST_MV_RD;
                    bair_pkg::PLAN_MOVE_DOWN:
                        n_state = i_status.cnt_zero ? ST_FINISH : ST_MV_RD;
                    default:
                        n_state = ST_FINISH;
                endcase
            end
            ST_WRITE: begin
                o_cmd.wr_step = 1'b1;
                if (i_status.cnt_one) begin
                    n_state = ST_FINISH;
                end
            end
            ST_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_RD_CAP;
            end
            ST_RD_CAP: begin
                o_cmd.rd_cap = 1'b1;
                n_state      = i_status.cnt_zero ? ST_FINISH : ST_RD_ISSUE;
            end
            ST_MV_RD: begin
                o_cmd.mv_read = 1'b1;
                n_state       = ST_MV_WR;
            end
            ST_MV_WR: begin
                o_cmd.mv_write = 1'b1;
                if (!i_status.cnt_one) begin
                    n_state = ST_MV_RD;
                end else if (i_status.plan == bair_pkg::PLAN_MOVE_UP) begin
                    n_state = ST_INS_WR;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_INS_WR: begin
                // The gap opened by the upward move takes the new byte.
                o_cmd.wr_step = 1'b1;
                n_state       = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `BAIR_ASSERT_NEXT(a_accept_starts_work, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == ST_START, "accepted transaction did not start work")

endmodule

### hdl/byte_array_insert_remove_engine.sv
// ----------------------------------------------------------------------------
// Byte array insert/remove engine
// Byte store with a fill level: append, insert, remove, replace, read, pop,
// clear, fill and resize, one request at a time.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake   | Payload
// i_req   | in        | valid/ready | mode, index, width_code, write_value
// o_rsp   | out       | valid/ready | read_value, ok, fill_level
//
// After reset a clearing pass zeroes the store; no request is taken until
// it ends. Each request has a start and a finish step around its memory work:
// a write per byte for append/replace/fill, an issue and a capture per byte
// for reads, and a read and a write per moved byte for insert and remove.
// The result waits in an output register while the next request is taken;
// a stalled response holds only the end of the following request.
// ----------------------------------------------------------------------------
module byte_array_insert_remove_engine #(
    parameter int STORE_BYTES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bair_req_if.sink     i_req,
    bair_rsp_if.source   o_rsp
);

    bair_pkg::t_cmd    w_cmd;
    bair_pkg::t_status w_status;
    logic              w_in_ready;

    assign i_req.ready = w_in_ready;

    bair_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bair_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_mode        (i_req.mode),
        .i_index       (i_req.index),
        .i_width_code  (i_req.width_code),
        .i_write_value (i_req.write_value),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_read_value  (o_rsp.read_value),
        .o_ok          (o_rsp.ok),
        .o_fill_level  (o_rsp.fill_level)
    );

endmodule

### verif/bair_response_checker.sv
// ----------------------------------------------------------------------------
// Byte array engine response checker
// Watches both channels, keeps its own image of the byte store and fill
// level, and compares every response transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bair_response_checker #(
    parameter int STORE_BYTES = 256
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bair_req_if   i_req,
    bair_rsp_if   i_rsp,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_fill_level
);
    import bair_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               ok;
        logic [LEVEL_W-1:0] fill_level;
    } t_response;

    logic [BYTE_W-1:0] cell_image [STORE_BYTES];
    int                used_bytes;
    int                mismatch_count;
    t_response         awaited_responses [$];

    // Applies one request to the image and returns the response it must produce.
    function automatic t_response apply_request(input logic [MODE_W-1:0]  mode,
                                                input logic [INDEX_W-1:0] index,
                                                input logic [WCODE_W-1:0] wcode,
                                                input logic [VALUE_W-1:0] value);
        t_response resp;
        int        nbytes;
        int        pos;
        int        k;
        resp = '0;
        case (wcode)
            WC_ONE:  nbytes = 1;
            WC_TWO:  nbytes = 2;
            WC_FOUR: nbytes = 4;
            default: nbytes = 0;
        endcase
        pos = int'(index);
        case (mode)
            MODE_APPEND, MODE_REPLACE: begin
                if (mode == MODE_APPEND) pos = used_bytes;
                if (nbytes != 0 &&
                    pos + nbytes <= ((mode == MODE_APPEND) ? STORE_BYTES : used_bytes)) begin
                    // Big-endian: the most significant byte lands at the lowest cell.
                    for (k = 0; k < nbytes; k++)
                        cell_image[pos + k] = BYTE_W'(value >> (8 * (nbytes - 1 - k)));
                    if (mode == MODE_APPEND) used_bytes += nbytes;
                    resp.ok = 1'b1;
                end
            end
            MODE_INSERT: begin
                if (pos <= used_bytes && used_bytes < STORE_BYTES) begin
                    for (k = used_bytes; k > pos; k--)
                        cell_image[k] = cell_image[k - 1];
                    cell_image[pos] = value[BYTE_W-1:0];
                    used_bytes++;
                    resp.ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                // The old last cell keeps its content once the level drops.
                if (pos < used_bytes) begin
                    for (k = pos; k + 1 < used_bytes; k++)
                        cell_image[k] = cell_image[k + 1];
                    used_bytes--;
                    resp.ok = 1'b1;
                end
            end
            MODE_READ_AT, MODE_READ_LAST, MODE_TAKE_LAST: begin
                if (mode != MODE_READ_AT) pos = used_bytes - nbytes;
                if (nbytes != 0 && pos >= 0 && pos + nbytes <= used_bytes) begin
                    for (k = 0; k < nbytes; k++)
                        resp.read_value = (resp.read_value << 8) | cell_image[pos + k];
                    if (mode == MODE_TAKE_LAST) used_bytes -= nbytes;
                    resp.ok = 1'b1;
                end
            end
            MODE_CLEAR: begin
                used_bytes = 0;
                resp.ok = 1'b1;
            end
            MODE_FILL: begin
                for (k = 0; k < used_bytes; k++)
                    cell_image[k] = value[BYTE_W-1:0];
                resp.ok = 1'b1;
            end
            MODE_RESIZE: begin
                if (pos <= STORE_BYTES) begin
                    used_bytes = pos;
                    resp.ok = 1'b1;
                end
            end
            default: ;
        endcase
        resp.fill_level = LEVEL_W'(used_bytes);
        return resp;
    endfunction

    always @(posedge i_clk) begin
        t_response seen;
        t_response want;
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_BYTES; k++) cell_image[k] = '0;
            used_bytes = 0;
            mismatch_count = 0;
            awaited_responses.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                awaited_responses.push_back(apply_request(i_req.mode, i_req.index,
                                                          i_req.width_code, i_req.write_value));
            if (i_rsp.valid && i_rsp.ready) begin
                seen = '{read_value: i_rsp.read_value, ok: i_rsp.ok,
                         fill_level: i_rsp.fill_level};
                if (awaited_responses.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected response: value %h ok %b level %0d",
                                 seen.read_value, seen.ok, seen.fill_level);
                end else begin
                    want = awaited_responses.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("response mismatch: expected value %h ok %b level %0d, got value %h ok %b level %0d",
                                     want.read_value, want.ok, want.fill_level,
                                     seen.read_value, seen.ok, seen.fill_level);
                    end
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= awaited_responses.size();
        o_fill_level <= used_bytes;
    end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Byte array engine testbench
// Drives directed and random requests into the engine under changing idle
// patterns on both channels and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import bair_pkg::*;

    localparam int STORE_BYTES  = 256;
    localparam int RANDOM_ITEMS = 1600;
    localparam int SOFT_CAP     = 48;

    localparam logic [MODE_W-1:0]  MODE_UNUSED_LOW = 4'd10;
    localparam logic [MODE_W-1:0]  MODE_UNUSED_TOP = 4'd15;
    localparam logic [WCODE_W-1:0] WC_INVALID      = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   tx_idle_pct = 17;
    int   rx_idle_pct = 59;
    int   fail_count;
    int   pending_count;
    int   model_level;

    bair_req_if req_ch();
    bair_rsp_if rsp_ch();

    byte_array_insert_remove_engine #(
        .STORE_BYTES(STORE_BYTES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bair_response_checker #(
        .STORE_BYTES(STORE_BYTES)
    ) response_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_fill_level (model_level)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic issue_request(input logic [MODE_W-1:0]  mode,
                                 input logic [INDEX_W-1:0] index,
                                 input logic [WCODE_W-1:0] wcode,
                                 input logic [VALUE_W-1:0] value);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.mode        = mode;
        req_ch.index       = index;
        req_ch.width_code  = wcode;
        req_ch.write_value = value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_until_drained();
        req_ch.valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    // Mostly a legal position up to hi, sometimes just past it, sometimes anything.
    function automatic logic [INDEX_W-1:0] aim_index(input int hi, input int boundary);
        int sel;
        sel = $urandom_range(0, 9);
        if (boundary < 0) boundary = 0;
        if (sel == 0) return INDEX_W'($urandom_range(0, 511));
        if (sel == 1 || hi < 0) return INDEX_W'(boundary);
        return INDEX_W'($urandom_range(0, hi));
    endfunction

    initial begin
        int                 pick;
        int                 nb;
        int                 lvl;
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] idx;
        logic [WCODE_W-1:0] wcode;

        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_APPEND;
        req_ch.index       = '0;
        req_ch.width_code  = WC_ONE;
        req_ch.write_value = '0;
        rsp_ch.ready       = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty store, all widths, shifting, bounds, full store.
        issue_request(MODE_READ_LAST, 9'd0, WC_ONE, 32'h0);
        issue_request(MODE_REMOVE, 9'd0, WC_ONE, 32'h0);
        issue_request(MODE_APPEND, 9'd0, WC_FOUR, 32'hDEAD_BEEF);
        issue_request(MODE_APPEND, 9'd0, WC_TWO, 32'hFFFF_1234);
        issue_request(MODE_APPEND, 9'd0, WC_ONE, 32'h0000_00AB);
        issue_request(MODE_APPEND, 9'd0, WC_INVALID, 32'h1111_1111);
        issue_request(MODE_INSERT, 9'd0, WC_ONE, 32'h0000_005A);
        issue_request(MODE_INSERT, 9'd8, WC_ONE, 32'hFFFF_FF7E);
        issue_request(MODE_INSERT, 9'd10, WC_ONE, 32'h0000_0001);
        issue_request(MODE_REMOVE, 9'd3, WC_ONE, 32'h0);
        issue_request(MODE_REPLACE, 9'd0, WC_FOUR, 32'h0102_0304);
        issue_request(MODE_REPLACE, 9'd7, WC_TWO, 32'hCAFE_F00D);
        issue_request(MODE_READ_AT, 9'd0, WC_FOUR, 32'h0);
        issue_request(MODE_READ_AT, 9'd6, WC_TWO, 32'h0);
        issue_request(MODE_READ_AT, 9'd0, WC_INVALID, 32'h0);
        issue_request(MODE_TAKE_LAST, 9'd0, WC_TWO, 32'h0);
        issue_request(MODE_READ_LAST, 9'd0, WC_FOUR, 32'h0);
        issue_request(MODE_FILL, 9'd0, WC_ONE, 32'h0000_00C3);
        issue_request(MODE_RESIZE, 9'd511, WC_ONE, 32'h0);
        issue_request(MODE_RESIZE, 9'd256, WC_ONE, 32'h0);
        issue_request(MODE_APPEND, 9'd0, WC_ONE, 32'h0000_00FF);
        issue_request(MODE_INSERT, 9'd0, WC_ONE, 32'h0000_0042);
        issue_request(MODE_READ_AT, 9'd252, WC_FOUR, 32'h0);
        issue_request(MODE_UNUSED_TOP, 9'h1FF, WC_INVALID, 32'hFFFF_FFFF);
        issue_request(MODE_CLEAR, 9'd0, WC_ONE, 32'h0);

        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (item == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 59;
                rx_idle_pct = 17;
            end
            if (item == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (item == RANDOM_ITEMS / 2) wait_until_drained();

            // Now and then grow the store to capacity and shift near the top.
            if (item % 550 == 275) begin
                while (model_level + 4 <= STORE_BYTES)
                    issue_request(MODE_APPEND, 9'd0, WC_FOUR, $urandom);
                while (model_level < STORE_BYTES)
                    issue_request(MODE_INSERT, INDEX_W'($urandom_range(0, model_level)),
                                  WC_ONE, $urandom);
                issue_request(MODE_INSERT, INDEX_W'(STORE_BYTES), WC_ONE, $urandom);
                issue_request(MODE_APPEND, 9'd0, WC_ONE, $urandom);
                repeat (4)
                    issue_request(MODE_REMOVE, INDEX_W'($urandom_range(0, model_level - 1)),
                                  WC_ONE, $urandom);
                issue_request(MODE_READ_AT, INDEX_W'($urandom_range(0, model_level - 4)),
                              WC_FOUR, $urandom);
                issue_request(MODE_TAKE_LAST, 9'd0, WC_FOUR, $urandom);
                issue_request(MODE_CLEAR, INDEX_W'($urandom_range(0, 511)), WC_ONE, $urandom);
            end

            lvl   = model_level;
            wcode = ($urandom_range(0, 19) == 0) ? WC_INVALID : WCODE_W'($urandom_range(0, 2));
            nb    = (wcode == WC_ONE) ? 1 : (wcode == WC_TWO) ? 2 : 4;
            idx   = INDEX_W'($urandom_range(0, 511));
            pick  = $urandom_range(0, 99);
            if (pick < 3)       mode = MODE_W'($urandom_range(MODE_UNUSED_LOW, MODE_UNUSED_TOP));
            else if (pick < 25) mode = (lvl > SOFT_CAP) ? MODE_TAKE_LAST : MODE_APPEND;
            else if (pick < 37) mode = (lvl > SOFT_CAP) ? MODE_REMOVE : MODE_INSERT;
            else if (pick < 49) mode = MODE_REMOVE;
            else if (pick < 59) mode = MODE_REPLACE;
            else if (pick < 71) mode = MODE_READ_AT;
            else if (pick < 77) mode = MODE_READ_LAST;
            else if (pick < 85) mode = MODE_TAKE_LAST;
            else if (pick < 88) mode = MODE_CLEAR;
            else if (pick < 92) mode = MODE_FILL;
            else                mode = MODE_RESIZE;

            case (mode)
                MODE_INSERT:                idx = aim_index(lvl, lvl + 1);
                MODE_REMOVE:                idx = aim_index(lvl - 1, lvl);
                MODE_REPLACE, MODE_READ_AT: idx = aim_index(lvl - nb, lvl - nb + 1);
                MODE_RESIZE: begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)      idx = INDEX_W'(STORE_BYTES);
                    else if (pick == 1) idx = INDEX_W'($urandom_range(STORE_BYTES + 1, 511));
                    else                idx = INDEX_W'($urandom_range(0, SOFT_CAP + 8));
                end
                default: ;
            endcase
            issue_request(mode, idx, wcode, $urandom);
        end

        wait_until_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/bair_pkg.sv
hdl/bair_if.sv
hdl/bair_dp.sv
hdl/bair_ctrl.sv
hdl/byte_array_insert_remove_engine.sv
verif/bair_response_checker.sv
verif/testbench.sv
